// ===== rtl/core/ir_attitude_peak_normaliser_macros.svh =====
// Assertion macros shared by the attitude normaliser RTL.
`ifndef IR_ATTITUDE_PEAK_NORMALISER_MACROS_SVH
`define IR_ATTITUDE_PEAK_NORMALISER_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define IRAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define IRAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/irap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irap_pkg;

    localparam int LEVEL_BITS = 23;
    localparam int ANGLE_BITS = 16;
    localparam int ASIN_BITS  = 15;
    localparam int DECAY_BITS = 12;

    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN   = 23'sh400000;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX   = 23'sh3FFFFF;
    localparam logic        [LEVEL_BITS-1:0] SWING_RESET = 23'h200000;
    localparam logic        [LEVEL_BITS-1:0] SWING_FLOOR = 23'd1;
    localparam logic        [DECAY_BITS-1:0] DECAY_RESET = 12'd42;
    localparam int                           HALF_PI_Q14 = 25736;

    typedef enum logic [1:0] {
        AXIS_PITCH,
        AXIS_ROLL,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  load;
        logic  track;
        logic  setup;
        logic  check;
        logic  div_step;
        logic  clamp;
        logic  lookup;
        logic  store;
        logic  publish;
        axis_t axis;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

    // Taylor series sine, Q15 angle in, Q30 value out, truncating steps.
    function automatic logic signed [63:0] sine_q30(input logic [15:0] a);
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        t    = 64'(a) << 15;
        t2   = (t * t) >> 30;
        term = t;
        sum  = $signed(t);
        for (int n = 1; n <= 7; n++) begin
            prod = (term * t2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end
            else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // Arcsine of k/depth in Q2.14 radians by search over the sine.
    function automatic logic [ASIN_BITS-1:0] asin_entry(input int k, input int depth);
        logic [63:0]        lim;
        logic signed [63:0] s;
        int                 lo;
        int                 hi;
        int                 mid;
        lim = 64'(k) << 30;
        lo  = 0;
        hi  = HALF_PI_Q14;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            s   = sine_q30(16'(2 * mid - 1));
            if (s < 0 || ($unsigned(s) * 64'(depth)) <= lim) begin
                lo = mid;
            end
            else begin
                hi = mid - 1;
            end
        end
        return ASIN_BITS'(lo);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/irap_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ir_attitude_peak_normaliser_macros.svh"

module irap_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    output logic                   angle_valid,
    input  wire logic              angle_stall,
    output irap_pkg::cmd_t         cmd,
    input  wire irap_pkg::status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRACK,
        ST_SETUP,
        ST_CHECK,
        ST_DIVIDE,
        ST_CLAMP,
        ST_LOOKUP,
        ST_STORE,
        ST_PUBLISH
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    irap_pkg::axis_t axis_reg;
    irap_pkg::axis_t axis_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;
    logic            slot_free;

    assign accept       = (state_reg == ST_IDLE) && sample_valid;
    assign slot_free    = !out_valid_reg || !angle_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign angle_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && angle_stall;
        cmd            = '0;
        cmd.axis       = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = ST_TRACK;
                    axis_next  = irap_pkg::AXIS_PITCH;
                end
            end
            ST_TRACK:
            begin
                cmd.track = 1'b1;
                case (axis_reg)
                    irap_pkg::AXIS_PITCH: axis_next = irap_pkg::AXIS_ROLL;
                    irap_pkg::AXIS_ROLL:  axis_next = irap_pkg::AXIS_Z;
                    default:
                    begin
                        axis_next  = irap_pkg::AXIS_PITCH;
                        state_next = ST_SETUP;
                    end
                endcase
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (axis_reg == irap_pkg::AXIS_PITCH)
                begin
                    axis_next  = irap_pkg::AXIS_ROLL;
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= irap_pkg::AXIS_PITCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `IRAP_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, sample_stall, "accepted item not held off")
    `IRAP_ASSERT_IMP(a_valid_source, clk, rst_n, $rose(out_valid_reg),
                     $past(state_reg == ST_PUBLISH), "result valid without publish")

endmodule

`default_nettype wire

// ===== rtl/core/irap_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ir_attitude_peak_normaliser_macros.svh"

module irap_datapath
#(
    parameter int SAMPLE_BITS       = 12,
    parameter int ANGLE_TABLE_DEPTH = 1024
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire irap_pkg::cmd_t                          cmd,
    output irap_pkg::status_t                            status,
    input  wire logic                                    cfg_write,
    input  wire logic [irap_pkg::DECAY_BITS-1:0]         cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]                  pitch_sample,
    input  wire logic [SAMPLE_BITS-1:0]                  roll_sample,
    input  wire logic [SAMPLE_BITS-1:0]                  z_sample,
    output logic signed [irap_pkg::ANGLE_BITS-1:0]       pitch_angle,
    output logic signed [irap_pkg::ANGLE_BITS-1:0]       roll_angle,
    output logic [irap_pkg::LEVEL_BITS-1:0]              swing_level,
    output logic signed [irap_pkg::LEVEL_BITS-1:0]       max_level,
    output logic signed [irap_pkg::LEVEL_BITS-1:0]       min_level
);

    localparam int LB  = irap_pkg::LEVEL_BITS;
    localparam int AB  = irap_pkg::ANGLE_BITS;
    localparam int QB  = irap_pkg::ASIN_BITS;
    localparam int DW  = $clog2(ANGLE_TABLE_DEPTH + 1);
    localparam int NW  = LB + 1 + DW;
    localparam int DVW = LB + DW;
    localparam int CW  = $clog2(DW);
    localparam int PAD = LB - SAMPLE_BITS;
    localparam logic [DW-1:0] DEPTH_K = DW'(ANGLE_TABLE_DEPTH);

    logic [QB-1:0] asin_rom [ANGLE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= ANGLE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [QB-1:0] ENTRY = irap_pkg::asin_entry(g, ANGLE_TABLE_DEPTH);
        assign asin_rom[g] = ENTRY;
    end

    logic [irap_pkg::DECAY_BITS-1:0] decay_reg;
    logic [LB-1:0]                   swing_reg;
    logic signed [LB-1:0]            max_reg;
    logic signed [LB-1:0]            min_reg;
    logic signed [LB-1:0]            pitch_c_reg;
    logic signed [LB-1:0]            roll_c_reg;
    logic signed [LB-1:0]            z_c_reg;
    logic [NW-1:0]                   num_reg;
    logic [DVW-1:0]                  dvs_reg;
    logic [DW-1:0]                   q_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            over_reg;
    logic                            sign_reg;
    logic [DW-1:0]                   k_reg;
    logic [QB-1:0]                   rom_q_reg;
    logic signed [AB-1:0]            pitch_ang_reg;
    logic signed [AB-1:0]            roll_ang_reg;
    logic signed [AB-1:0]            pitch_out_reg;
    logic signed [AB-1:0]            roll_out_reg;
    logic [LB-1:0]                   swing_out_reg;
    logic signed [LB-1:0]            max_out_reg;
    logic signed [LB-1:0]            min_out_reg;

    logic signed [LB-1:0]            pitch_cen;
    logic signed [LB:0]              pitch_neg;
    logic signed [LB-1:0]            pitch_next;
    logic signed [LB-1:0]            roll_next;
    logic signed [LB-1:0]            z_next;
    logic signed [LB-1:0]            axis_val;
    logic signed [LB:0]              axis_ext;
    logic signed [LB:0]              axis_neg;
    logic [LB-1:0]                   axis_mag;
    logic [LB-1:0]                   peak_hold;
    logic [LB-1:0]                   peak_dec;
    logic [LB-1:0]                   swing_next;
    logic signed [LB-1:0]            max_next;
    logic signed [LB-1:0]            min_next;
    logic [NW-1:0]                   num_next;
    logic                            over_next;
    logic                            div_ge;
    logic [DW-1:0]                   k_next;
    logic [AB-1:0]                   ang_mag;
    logic signed [AB-1:0]            ang_next;

    assign pitch_cen  = {~pitch_sample[SAMPLE_BITS-1], pitch_sample[SAMPLE_BITS-2:0], {PAD{1'b0}}};
    assign roll_next  = {~roll_sample[SAMPLE_BITS-1], roll_sample[SAMPLE_BITS-2:0], {PAD{1'b0}}};
    assign z_next     = {~z_sample[SAMPLE_BITS-1], z_sample[SAMPLE_BITS-2:0], {PAD{1'b0}}};
    assign pitch_neg  = -{pitch_cen[LB-1], pitch_cen};
    assign pitch_next = (pitch_cen == irap_pkg::LEVEL_MIN) ? irap_pkg::LEVEL_MAX
                                                            : LB'(pitch_neg);

    always_comb
    begin
        case (cmd.axis)
            irap_pkg::AXIS_PITCH: axis_val = pitch_c_reg;
            irap_pkg::AXIS_ROLL:  axis_val = roll_c_reg;
            default:              axis_val = z_c_reg;
        endcase
        axis_ext   = {axis_val[LB-1], axis_val};
        axis_neg   = -axis_ext;
        axis_mag   = axis_val[LB-1] ? LB'(axis_neg) : LB'(axis_ext);
        peak_hold  = (swing_reg > axis_mag) ? swing_reg : axis_mag;
        peak_dec   = (peak_hold > LB'(decay_reg)) ? peak_hold - LB'(decay_reg) : '0;
        swing_next = (peak_dec < irap_pkg::SWING_FLOOR) ? irap_pkg::SWING_FLOOR : peak_dec;
        max_next   = max_reg;
        min_next   = min_reg;
        if (axis_val > max_reg)
        begin
            max_next = axis_val;
        end
        else if (axis_val < min_reg)
        begin
            min_next = axis_val;
        end
        num_next  = ((NW'(axis_mag) * NW'(ANGLE_TABLE_DEPTH)) << 1) + NW'(swing_reg);
        over_next = num_reg >= (NW'({swing_reg, 1'b0}) << DW);
        div_ge    = NW'(dvs_reg) <= num_reg;
        k_next    = (over_reg || (q_reg > DEPTH_K)) ? DEPTH_K : q_reg;
        ang_mag   = AB'(rom_q_reg);
        ang_next  = sign_reg ? -$signed(ang_mag) : $signed(ang_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= irap_pkg::DECAY_RESET;
            swing_reg <= irap_pkg::SWING_RESET;
            max_reg   <= irap_pkg::LEVEL_MIN;
            min_reg   <= irap_pkg::LEVEL_MAX;
        end
        else
        begin
            if (cfg_write)
            begin
                decay_reg <= cfg_data;
            end
            if (cmd.track)
            begin
                swing_reg <= swing_next;
                max_reg   <= max_next;
                min_reg   <= min_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pitch_c_reg <= pitch_next;
            roll_c_reg  <= roll_next;
            z_c_reg     <= z_next;
        end
        if (cmd.setup)
        begin
            num_reg  <= num_next;
            sign_reg <= axis_val[LB-1];
        end
        if (cmd.check)
        begin
            over_reg <= over_next;
            dvs_reg  <= DVW'({swing_reg, 1'b0}) << (DW - 1);
            cnt_reg  <= CW'(DW - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                num_reg <= num_reg - NW'(dvs_reg);
            end
            q_reg   <= {q_reg[DW-2:0], div_ge};
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.clamp)
        begin
            k_reg <= k_next;
        end
        if (cmd.lookup)
        begin
            rom_q_reg <= asin_rom[k_reg];
        end
        if (cmd.store)
        begin
            if (cmd.axis == irap_pkg::AXIS_PITCH)
            begin
                pitch_ang_reg <= ang_next;
            end
            else
            begin
                roll_ang_reg <= ang_next;
            end
        end
        if (cmd.publish)
        begin
            pitch_out_reg <= pitch_ang_reg;
            roll_out_reg  <= roll_ang_reg;
            swing_out_reg <= swing_reg;
            max_out_reg   <= max_reg;
            min_out_reg   <= min_reg;
        end
    end

    assign status.div_last = (cnt_reg == '0);
    assign pitch_angle     = pitch_out_reg;
    assign roll_angle      = roll_out_reg;
    assign swing_level     = swing_out_reg;
    assign max_level       = max_out_reg;
    assign min_level       = min_out_reg;

    `IRAP_ASSERT_IMP(a_swing_nonzero, clk, rst_n, 1'b1, swing_reg != '0, "swing peak reached zero")
    `IRAP_ASSERT_IMP(a_index_range, clk, rst_n, cmd.lookup, k_reg <= DEPTH_K,
                     "table index beyond depth")

endmodule

`default_nettype wire

// ===== rtl/core/ir_attitude_peak_normaliser.sv =====
// Attitude from three IR thermopile readings. Each accepted transaction carries
// pitch, roll and z samples; the block centres them to signed Q1.22 (pitch
// negated), updates the running max/min and the decaying swing peak axis by axis,
// then returns pitch and roll angles as asin(level / swing) in Q2.14 radians
// with the swing, max and min levels. A new item is not accepted until the current
// one is published (sample_stall is high outside idle); the restoring divider,
// one quotient bit per cycle and run once per angle, accounts for most of this. A
// finished result waits in the output register while the next item is processed.
// decay_step (reset 42) is to be written through the cfg channel only while the
// block is idle; the block itself does not enforce this. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module ir_attitude_peak_normaliser
#(
    parameter int SAMPLE_BITS       = 12,
    parameter int ANGLE_TABLE_DEPTH = 1024
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [irap_pkg::DECAY_BITS-1:0]         cfg_data,
    input  wire logic                                    sample_valid,
    output logic                                         sample_stall,
    input  wire logic [SAMPLE_BITS-1:0]                  pitch_sample,
    input  wire logic [SAMPLE_BITS-1:0]                  roll_sample,
    input  wire logic [SAMPLE_BITS-1:0]                  z_sample,
    output logic                                         angle_valid,
    input  wire logic                                    angle_stall,
    output logic signed [irap_pkg::ANGLE_BITS-1:0]       pitch_angle,
    output logic signed [irap_pkg::ANGLE_BITS-1:0]       roll_angle,
    output logic [irap_pkg::LEVEL_BITS-1:0]              swing_level,
    output logic signed [irap_pkg::LEVEL_BITS-1:0]       max_level,
    output logic signed [irap_pkg::LEVEL_BITS-1:0]       min_level
);

    irap_pkg::cmd_t    cmd;
    irap_pkg::status_t status;

    assign cfg_ready = 1'b1;

    irap_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .cmd          (cmd),
        .status       (status)
    );

    irap_datapath
    #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .ANGLE_TABLE_DEPTH (ANGLE_TABLE_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .pitch_sample (pitch_sample),
        .roll_sample  (roll_sample),
        .z_sample     (z_sample),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .swing_level  (swing_level),
        .max_level    (max_level),
        .min_level    (min_level)
    );

endmodule

`default_nettype wire
